### sv/fletcher16_frame_checker_macros.svh
// Assertion macros for the Fletcher-16 frame checker.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef FLETCHER16_FRAME_CHECKER_MACROS_SVH
`define FLETCHER16_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define F16FC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("f16fc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define F16FC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("f16fc: next-cycle check failed");

`endif

### sv/f16fc_pkg.sv
// Package for the Fletcher-16 frame checker: types, constants and helper functions.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package f16fc_pkg;

	localparam int MAX_LINE_DEFAULT = 255;
	localparam int HEX_DIGITS       = 4;
	localparam int SEQ_DIGITS       = 6;
	localparam int MIN_FRAME        = 5;
	localparam int SEQ_W            = 20;

	localparam logic [7:0] SUM_INIT   = 8'hff;
	localparam logic [7:0] CHAR_DATA  = 8'h31; // '1'
	localparam logic [7:0] CHAR_END   = 8'h39; // '9'
	localparam logic [7:0] CHAR_ACK   = 8'h32; // '2'
	localparam logic [7:0] CHAR_TMO   = 8'h34; // '4'
	localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'
	localparam logic [7:0] CHAR_LA    = 8'h61; // 'a'
	localparam logic [7:0] CHAR_LF    = 8'h66; // 'f'
	localparam logic [7:0] CHAR_UA    = 8'h41; // 'A'
	localparam logic [7:0] CHAR_UF    = 8'h46; // 'F'

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_END     = 3'd1,
		KIND_ACK     = 3'd2,
		KIND_TIMEOUT = 3'd3,
		KIND_OTHER   = 3'd4
	} kind_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Ones' complement style addition: the carry is folded back into bit 0.
	function automatic logic [7:0] add_end_around(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		logic [8:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[7:0]} + {8'd0, s[8]};
		return f[7:0];
	endfunction

	function automatic hex_digit_t hex_digit(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b1;
		d.value = 4'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d.value = c[3:0];
		end else if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF)) begin
			// Letters a-f and A-F share their low three bits: 1..6.
			d.value = 4'd9 + {1'b0, c[2:0]};
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	function automatic kind_t kind_code(input logic [7:0] b);
		kind_t k;
		case (b)
			CHAR_DATA: k = KIND_DATA;
			CHAR_END:  k = KIND_END;
			CHAR_ACK:  k = KIND_ACK;
			CHAR_TMO:  k = KIND_TIMEOUT;
			default:   k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

### sv/f16fc_if.sv
// Valid/ready channel interfaces for the Fletcher-16 frame checker.
// Depends on f16fc_pkg for the sequence number width.
`timescale 1ns / 1ps

interface f16fc_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_line;

	modport source (output valid, output rx_byte, output end_of_line, input ready);
	modport sink   (input valid, input rx_byte, input end_of_line, output ready);
endinterface

interface f16fc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         checksum_match;
	logic [15:0]                  computed_sum;
	logic [15:0]                  received_sum;
	logic [2:0]                   frame_kind;
	logic [f16fc_pkg::SEQ_W-1:0]  sequence_number;
	logic                         too_short;

	modport source (output valid, output checksum_match, output computed_sum,
		output received_sum, output frame_kind, output sequence_number,
		output too_short, input ready);
	modport sink   (input valid, input checksum_match, input computed_sum,
		input received_sum, input frame_kind, input sequence_number,
		input too_short, output ready);
endinterface

### sv/fletcher16_frame_checker.sv
// Fletcher-16 frame checker: one text line in, one check result per line out.
// Bytes arrive on the line channel, one per transaction; end_of_line marks the
// last byte. The first four bytes are a hex checksum, the rest the payload.
// On the last byte one result transaction carries the computed and received
// checksums, the match flag, frame kind, sequence number and too-short flag.
// A byte is held in the input register, then folded into the line state; a
// last byte loads the output register. Throughput: one byte per cycle, set by
// the combinational line state update (two chained end-around 8-bit additions
// and the hex/decimal parsers), unless a last byte waits for the result slot.
// When the receiver stalls, the result is held in the output register; bytes
// that do not end a line keep flowing, and a last byte waits in the input
// register until the result slot is free.
// Reset (arst_n low) clears the line state, empties both registers and drops
// any partly received line. Bytes beyond MAX_LINE-1 in a line are discarded,
// but their end_of_line flag still closes the line.
// Depends on f16fc_pkg, f16fc_if and fletcher16_frame_checker_macros.svh.
`timescale 1ns / 1ps
`include "fletcher16_frame_checker_macros.svh"

module fletcher16_frame_checker #(
	parameter int MAX_LINE = f16fc_pkg::MAX_LINE_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	f16fc_line_if.sink            line,
	f16fc_result_if.source        result
);

	localparam int POS_W = $clog2(MAX_LINE);
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(MAX_LINE - 1);
	localparam logic [POS_W-1:0] HEX_END   = POS_W'(f16fc_pkg::HEX_DIGITS);
	localparam logic [POS_W-1:0] SEQ_LAST  = POS_W'(f16fc_pkg::HEX_DIGITS
		+ f16fc_pkg::SEQ_DIGITS);
	localparam logic [POS_W-1:0] MIN_POS   = POS_W'(f16fc_pkg::MIN_FRAME);
	localparam int SW = f16fc_pkg::SEQ_W;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eol_s1;

	// Line state.
	logic [POS_W-1:0] pos_q;
	logic [15:0]      hex_q;
	logic             hex_stop_q;
	logic [7:0]       sum_lo_q;
	logic [7:0]       sum_hi_q;
	logic             cov_stop_q;
	logic [7:0]       kind_byte_q;
	logic [SW-1:0]    seq_q;
	logic             seq_stop_q;

	// Line state after the byte in the input register.
	logic [POS_W-1:0] pos_n;
	logic [15:0]      hex_n;
	logic             hex_stop_n;
	logic [7:0]       sum_lo_n;
	logic [7:0]       sum_hi_n;
	logic             cov_stop_n;
	logic [7:0]       kind_byte_n;
	logic [SW-1:0]    seq_n;
	logic             seq_stop_n;

	// Output register.
	logic                  out_valid_q;
	logic                  match_q;
	logic [15:0]           comp_q;
	logic [15:0]           recv_q;
	f16fc_pkg::kind_t      kind_q;
	logic [SW-1:0]         seqout_q;
	logic                  short_q;

	logic advance;
	logic emit;
	logic take;

	f16fc_pkg::hex_digit_t hd;
	logic [7:0]            v;
	logic                  is_dec;
	logic [SW-1:0]         seq_x10;
	logic                  short_n;
	logic [15:0]           comp_n;

	// A byte that does not end the line needs no result slot.
	assign advance = valid_s1 && (!eol_s1 || !out_valid_q || result.ready);
	assign emit    = advance && eol_s1;
	assign take    = line.valid && line.ready;
	assign line.ready = !valid_s1 || advance;

	always_comb begin
		pos_n       = pos_q;
		hex_n       = hex_q;
		hex_stop_n  = hex_stop_q;
		sum_lo_n    = sum_lo_q;
		sum_hi_n    = sum_hi_q;
		cov_stop_n  = cov_stop_q;
		kind_byte_n = kind_byte_q;
		seq_n       = seq_q;
		seq_stop_n  = seq_stop_q;
		hd          = f16fc_pkg::hex_digit(byte_s1);
		v           = 8'd0;
		is_dec      = 1'b0;
		seq_x10     = (seq_q << 3) + (seq_q << 1);

		if (pos_q < LAST_POS) begin
			pos_n = pos_q + 1'b1;
			if (pos_q < HEX_END) begin
				if (!hex_stop_q && hd.ok) begin
					hex_n = {hex_q[11:0], hd.value};
				end else begin
					hex_stop_n = 1'b1;
				end
			end else begin
				// A zero byte ends checksum coverage for the rest of the line.
				cov_stop_n = cov_stop_q || (byte_s1 == 8'd0);
				v = cov_stop_n ? 8'd0 : byte_s1;
				if (!cov_stop_n) begin
					sum_lo_n = f16fc_pkg::add_end_around(sum_lo_q, v);
					sum_hi_n = f16fc_pkg::add_end_around(sum_hi_q, sum_lo_n);
				end
				is_dec = (v >= f16fc_pkg::CHAR_ZERO) && (v <= f16fc_pkg::CHAR_NINE);
				if (pos_q == HEX_END) begin
					kind_byte_n = v;
				end else if (pos_q <= SEQ_LAST && !seq_stop_q) begin
					if (is_dec) begin
						seq_n = seq_x10 + SW'(v[3:0]);
					end else begin
						seq_stop_n = 1'b1;
					end
				end
			end
		end

		short_n = pos_n < MIN_POS;
		comp_n  = {sum_hi_n, sum_lo_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line.ready) begin
			valid_s1 <= line.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= line.rx_byte;
			eol_s1  <= line.end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hex_q       <= '0;
			hex_stop_q  <= 1'b0;
			sum_lo_q    <= f16fc_pkg::SUM_INIT;
			sum_hi_q    <= f16fc_pkg::SUM_INIT;
			cov_stop_q  <= 1'b0;
			kind_byte_q <= '0;
			seq_q       <= '0;
			seq_stop_q  <= 1'b0;
		end else if (emit) begin
			pos_q       <= '0;
			hex_q       <= '0;
			hex_stop_q  <= 1'b0;
			sum_lo_q    <= f16fc_pkg::SUM_INIT;
			sum_hi_q    <= f16fc_pkg::SUM_INIT;
			cov_stop_q  <= 1'b0;
			kind_byte_q <= '0;
			seq_q       <= '0;
			seq_stop_q  <= 1'b0;
		end else if (advance) begin
			pos_q       <= pos_n;
			hex_q       <= hex_n;
			hex_stop_q  <= hex_stop_n;
			sum_lo_q    <= sum_lo_n;
			sum_hi_q    <= sum_hi_n;
			cov_stop_q  <= cov_stop_n;
			kind_byte_q <= kind_byte_n;
			seq_q       <= seq_n;
			seq_stop_q  <= seq_stop_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			match_q  <= !short_n && (comp_n == hex_n);
			comp_q   <= comp_n;
			recv_q   <= hex_n;
			kind_q   <= f16fc_pkg::kind_code(kind_byte_n);
			seqout_q <= seq_n;
			short_q  <= short_n;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.checksum_match  = match_q;
	assign result.computed_sum    = comp_q;
	assign result.received_sum    = recv_q;
	assign result.frame_kind      = kind_q;
	assign result.sequence_number = seqout_q;
	assign result.too_short       = short_q;

	`F16FC_ASSERT_IMPLIES(a_match_means_equal, result.valid && result.checksum_match,
		result.computed_sum == result.received_sum && !result.too_short)
	`F16FC_ASSERT_IMPLIES(a_short_defaults, result.valid && result.too_short,
		result.computed_sum == 16'hffff && result.sequence_number == '0)
	`F16FC_ASSERT_NEXT(a_line_restarts, emit,
		pos_q == '0 && sum_lo_q == f16fc_pkg::SUM_INIT && !hex_stop_q && !seq_stop_q)
	`F16FC_ASSERT_NEXT(a_result_kept, result.valid && !result.ready,
		result.valid && $stable(comp_q) && $stable(seqout_q))

endmodule

### tb/f16fc_verdict_checker.sv
// Prediction and checking for the Fletcher-16 frame checker testbench.
// Watches the line and result channels; depends on f16fc_pkg and f16fc_if.
`timescale 1ns / 1ps

module f16fc_verdict_checker #(
	parameter int LINE_LIMIT = f16fc_pkg::MAX_LINE_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	f16fc_line_if   line_ch,
	f16fc_result_if result_ch,
	output int      mismatches,
	output int      results_seen
);
	import f16fc_pkg::*;

	typedef struct {
		logic              match;
		logic [15:0]       computed;
		logic [15:0]       received;
		kind_t             kind;
		logic [SEQ_W-1:0]  seq;
		logic              too_short;
	} line_verdict_t;

	line_verdict_t verdict_fifo[$];

	// Running state of the line being received.
	int               stored_bytes;
	logic [15:0]      hex_acc;
	logic             hex_halt;
	logic [7:0]       sum_lo;
	logic [7:0]       sum_hi;
	logic             cover_halt;
	logic [7:0]       kind_char;
	logic [SEQ_W-1:0] seq_acc;
	logic             seq_halt;

	function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[7:0] + {7'd0, t[8]};
	endfunction

	function automatic int hex_value_of(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return int'(c - CHAR_ZERO);
		if (c >= CHAR_LA && c <= CHAR_LF)
			return int'(c - CHAR_LA) + 10;
		if (c >= CHAR_UA && c <= CHAR_UF)
			return int'(c - CHAR_UA) + 10;
		return -1;
	endfunction

	function automatic kind_t kind_of(input logic [7:0] c);
		case (c)
			CHAR_DATA: return KIND_DATA;
			CHAR_END:  return KIND_END;
			CHAR_ACK:  return KIND_ACK;
			CHAR_TMO:  return KIND_TIMEOUT;
			default:   return KIND_OTHER;
		endcase
	endfunction

	task automatic clear_line();
		stored_bytes = 0;
		hex_acc      = '0;
		hex_halt     = 1'b0;
		sum_lo       = SUM_INIT;
		sum_hi       = SUM_INIT;
		cover_halt   = 1'b0;
		kind_char    = '0;
		seq_acc      = '0;
		seq_halt     = 1'b0;
	endtask

	task automatic fold_line_byte(input logic [7:0] b, input logic last);
		int            digit;
		logic [7:0]    v;
		line_verdict_t verdict;
		if (stored_bytes < LINE_LIMIT - 1) begin
			if (stored_bytes < HEX_DIGITS) begin
				digit = hex_value_of(b);
				if (!hex_halt && digit >= 0) begin
					hex_acc = {hex_acc[11:0], 4'(digit)};
				end else begin
					hex_halt = 1'b1;
				end
			end else begin
				// Once a zero byte is seen, the rest of the payload reads as zero.
				if (b == 8'd0)
					cover_halt = 1'b1;
				v = cover_halt ? 8'd0 : b;
				if (!cover_halt) begin
					sum_lo = fold_add(sum_lo, v);
					sum_hi = fold_add(sum_hi, sum_lo);
				end
				if (stored_bytes == HEX_DIGITS) begin
					kind_char = v;
				end else if (stored_bytes <= HEX_DIGITS + SEQ_DIGITS && !seq_halt) begin
					if (v >= CHAR_ZERO && v <= CHAR_NINE) begin
						seq_acc = seq_acc * 20'd10 + {12'd0, v - CHAR_ZERO};
					end else begin
						seq_halt = 1'b1;
					end
				end
			end
			stored_bytes++;
		end
		if (last) begin
			verdict.too_short = stored_bytes < MIN_FRAME;
			verdict.computed  = {sum_hi, sum_lo};
			verdict.received  = hex_acc;
			verdict.match     = !verdict.too_short && verdict.computed == hex_acc;
			verdict.kind      = kind_of(kind_char);
			verdict.seq       = seq_acc;
			verdict_fifo.push_back(verdict);
			clear_line();
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
			$time, results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		line_verdict_t want;
		if (verdict_fifo.size() == 0) begin
			report_mismatch("no line pending, computed_sum", result_ch.computed_sum, 0);
		end else begin
			want = verdict_fifo.pop_front();
			if (result_ch.checksum_match !== want.match)
				report_mismatch("checksum_match", result_ch.checksum_match, want.match);
			if (result_ch.computed_sum !== want.computed)
				report_mismatch("computed_sum", result_ch.computed_sum, want.computed);
			if (result_ch.received_sum !== want.received)
				report_mismatch("received_sum", result_ch.received_sum, want.received);
			if (result_ch.frame_kind !== 3'(want.kind))
				report_mismatch("frame_kind", result_ch.frame_kind, want.kind);
			if (result_ch.sequence_number !== want.seq)
				report_mismatch("sequence_number", result_ch.sequence_number, want.seq);
			if (result_ch.too_short !== want.too_short)
				report_mismatch("too_short", result_ch.too_short, want.too_short);
		end
		results_seen++;
	endtask

	// Results are handled before bytes, so a line closed at this edge can
	// never be matched against a result taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			verdict_fifo.delete();
			mismatches   = 0;
			results_seen = 0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			if (line_ch.valid && line_ch.ready)
				fold_line_byte(line_ch.rx_byte, line_ch.end_of_line);
		end
	end

endmodule

### tb/fletcher16_frame_checker_tb.sv
// Top of the Fletcher-16 frame checker testbench: clock, reset, line stimulus,
// result back-pressure and verdict. Depends on f16fc_pkg, f16fc_if and f16fc_verdict_checker.
`timescale 1ns / 1ps

module fletcher16_frame_checker_tb;
	import f16fc_pkg::*;

	localparam int ITEM_TARGET = 1700;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int STORED_PAYLOAD = MAX_LINE_DEFAULT - 1 - HEX_DIGITS;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	f16fc_line_if   line_ch();
	f16fc_result_if result_ch();

	int mismatches;
	int results_seen;
	int lines_sent = 0;
	int items_sent = 0;
	int burst_left = 10;
	int hold_requests = 0;
	int idle_cycles = 0;

	logic [7:0] payload_buf[$];
	logic [7:0] line_buf[$];

	fletcher16_frame_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.result (result_ch)
	);

	f16fc_verdict_checker verdict_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_ch      (line_ch),
		.result_ch    (result_ch),
		.mismatches   (mismatches),
		.results_seen (results_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Checksum over the bytes of payload_buf that the block will store.
	function automatic logic [15:0] payload_sum();
		logic [7:0] lo;
		logic [7:0] hi;
		logic [8:0] t;
		int         n;
		lo = SUM_INIT;
		hi = SUM_INIT;
		n  = payload_buf.size();
		if (n > STORED_PAYLOAD)
			n = STORED_PAYLOAD;
		for (int i = 0; i < n; i++) begin
			if (payload_buf[i] == 8'd0)
				break;
			t  = {1'b0, lo} + {1'b0, payload_buf[i]};
			lo = t[7:0] + {7'd0, t[8]};
			t  = {1'b0, hi} + {1'b0, lo};
			hi = t[7:0] + {7'd0, t[8]};
		end
		return {hi, lo};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return CHAR_ZERO + {4'd0, n};
		return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + {4'd0, n} - 8'd10;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			payload_buf.push_back(s[i]);
	endtask

	// Prefixes the payload with its checksum in hex; a spoilt frame has one bit flipped.
	task automatic wrap_frame(input bit spoil);
		logic [15:0] sum;
		int          k;
		sum = payload_sum();
		line_buf.delete();
		for (int d = 3; d >= 0; d--)
			line_buf.push_back(hex_char(sum[4*d +: 4]));
		foreach (payload_buf[i])
			line_buf.push_back(payload_buf[i]);
		if (spoil) begin
			k = $urandom_range(0, line_buf.size() - 1);
			line_buf[k] = line_buf[k] ^ (8'd1 << $urandom_range(0, 7));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		line_ch.valid       <= 1'b1;
		line_ch.rx_byte     <= b;
		line_ch.end_of_line <= last;
		@(posedge clk);
		while (!line_ch.ready)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				line_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(100, 300);
			else
				burst_left = $urandom_range(1, 30);
		end
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_byte(line_buf[i], i == line_buf.size() - 1);
		lines_sent++;
	endtask

	task automatic send_raw(input string s);
		payload_buf.delete();
		add_text(s);
		line_buf = payload_buf;
		send_line();
	endtask

	task automatic send_frame(input bit spoil);
		wrap_frame(spoil);
		send_line();
	endtask

	task automatic random_frame();
		int          n;
		logic [7:0]  kind_pick[5];
		payload_buf.delete();
		kind_pick = '{CHAR_DATA, CHAR_END, CHAR_ACK, CHAR_TMO, 8'($urandom_range(0, 255))};
		payload_buf.push_back(kind_pick[$urandom_range(0, 4)]);
		n = $urandom_range(0, 7);
		repeat (n) payload_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
		n = $urandom_range(0, 12);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				payload_buf.push_back(8'($urandom_range(0, 255)));
			else
				payload_buf.push_back(8'($urandom_range(32, 126)));
		end
		if ($urandom_range(0, 11) == 0)
			payload_buf[$urandom_range(0, payload_buf.size() - 1)] = 8'd0;
		send_frame($urandom_range(0, 9) == 0);
	endtask

	task automatic long_frame();
		int n;
		payload_buf.delete();
		payload_buf.push_back(CHAR_DATA);
		n = $urandom_range(235, 295);
		repeat (n) payload_buf.push_back(8'($urandom_range(1, 255)));
		send_frame(1'b0);
	endtask

	task automatic noise_line(input int lo, input int hi);
		int n;
		line_buf.delete();
		n = $urandom_range(lo, hi);
		repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		send_line();
	endtask

	// Drops valid and waits until every closed line has had its result.
	task automatic drain();
		line_ch.valid <= 1'b0;
		@(posedge clk);
		wait (results_seen == lines_sent);
	endtask

	initial begin
		bit held;
		bit drained;
		int pick;
		held    = 1'b0;
		drained = 1'b0;
		arst_n              <= 1'b0;
		line_ch.valid       <= 1'b0;
		line_ch.rx_byte     <= 8'd0;
		line_ch.end_of_line <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: no payload at all, the shortest full frame, a zero
		// byte in the payload, six digits of sequence and a hex digit run cut short.
		send_raw("1");
		payload_buf.delete();
		add_text("1");
		send_frame(1'b0);
		payload_buf.delete();
		add_text("9");
		payload_buf.push_back(8'd0);
		add_text("7");
		send_frame(1'b0);
		payload_buf.delete();
		add_text("4999999");
		send_frame(1'b0);
		send_raw("12G42");

		while (items_sent < ITEM_TARGET) begin
			if (!held && items_sent > 400) begin
				hold_requests++;
				held = 1'b1;
			end
			if (!drained && items_sent > 900) begin
				drain();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 3)
				long_frame();
			else if (pick < 65)
				random_frame();
			else if (pick < 80)
				noise_line(1, 4);
			else
				noise_line(1, 24);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result back-pressure: segments of free, coin-toss and sparse acceptance,
	// interrupted by a long hold-off whenever the stimulus asks for one.
	initial begin
		int       holds_served;
		int       hold_left;
		int       seg_left;
		rx_mode_t mode;
		logic     rdy;
		holds_served = 0;
		hold_left    = 0;
		seg_left     = 0;
		mode         = RX_FREE;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_served < hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				mode     = rx_mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(20, 120);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (mode)
					RX_FREE:   rdy = 1'b1;
					RX_COIN:   rdy = 1'($urandom_range(0, 1));
					default:   rdy = (seg_left % 4) == 0;
				endcase
			end
			result_ch.ready <= rdy;
			@(posedge clk);
		end
	end

	// Watchdog: ends the run if no transaction completes for too long.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((line_ch.valid && line_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

### files.f
+incdir+sv
sv/f16fc_pkg.sv
sv/f16fc_if.sv
sv/fletcher16_frame_checker.sv
tb/f16fc_verdict_checker.sv
tb/fletcher16_frame_checker_tb.sv
